[hw/rtl/dasd_pkg.sv]
package dasd_pkg;

	// field widths
	localparam int ANGLE_W   = 15;
	localparam int CFG_IDX_W = 1;

	// ring of recent headings: depth is a power of two so the mean is a shift
	localparam int AVG_LOG2  = 2;
	localparam int AVG_DEPTH = 1 << AVG_LOG2;
	localparam int SUM_W     = ANGLE_W + AVG_LOG2;

	// angle constants, 1/64 degree units
	localparam logic [ANGLE_W:0]   DEG180     = 16'd11520;
	localparam logic [ANGLE_W:0]   DEG360     = 16'd23040;
	localparam logic [ANGLE_W-1:0] JUMP_LIMIT = 15'd19200;
	localparam logic [ANGLE_W:0]   WINDOW     = 16'd192;

	// register reset values
	localparam logic [ANGLE_W-1:0] OPEN_ANGLE_RST = 15'd5760;
	localparam logic [ANGLE_W-1:0] SNAP_ANGLE_RST = 15'd2560;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OPEN_ANGLE = 1'b0,
		REG_SNAP_ANGLE = 1'b1
	} reg_idx_t;

	// failure codes
	typedef enum logic [1:0] {
		FAIL_NONE            = 2'd0,
		FAIL_OPEN_NOT_CLOSED = 2'd1,
		FAIL_CLOSED_NO_OPEN  = 2'd2
	} fail_code_t;

	typedef logic [ANGLE_W-1:0] angle_t;
	typedef logic [SUM_W-1:0]   sum_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] heading_angle;
		logic               tilt_negative;
	} in_beat_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] avg_angle;
		logic               open_event;
		logic               snap_event;
		logic [1:0]         failure_code;
	} out_beat_t;

	// detector verdict handed from the window logic to the top level
	typedef struct packed {
		logic       open_event;
		logic       snap_event;
		fail_code_t failure_code;
	} detect_res_t;

endpackage

[hw/rtl/dasd_if.sv]
interface dasd_in_if;
	import dasd_pkg::*;

	logic     valid;
	logic     ready;
	in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dasd_out_if;
	import dasd_pkg::*;

	logic      valid;
	logic      ready;
	out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/dasd_cell.sv]
module dasd_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            load,
	input  dasd_pkg::angle_t fill_val,
	input  dasd_pkg::angle_t prev_val,
	input  dasd_pkg::sum_t  sum_in,
	output dasd_pkg::sum_t  sum_out,
	output dasd_pkg::angle_t val_q
);
	import dasd_pkg::*;

	angle_t nxt_val;

	// value this cell holds after the beat: neighbor's value or the reload value
	assign nxt_val = load ? fill_val : prev_val;

	// running sum of the ring contents after the beat
	assign sum_out = sum_in + SUM_W'(nxt_val);

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= nxt_val;
		end
	end

endmodule

[hw/rtl/dasd_detect.sv]
module dasd_detect (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  dasd_pkg::angle_t   avg,
	input  dasd_pkg::angle_t   open_angle,
	input  dasd_pkg::angle_t   snap_angle,
	output dasd_pkg::detect_res_t res
);
	import dasd_pkg::*;

	logic armed_q;
	logic open_hit;
	logic snap_hit;
	logic arm_set;
	logic armed_mid;
	logic armed_nxt;

	// strictly within the window around a reference heading
	function automatic logic in_window(input angle_t v, input angle_t ref_angle);
		logic [ANGLE_W:0] v_ext;
		logic [ANGLE_W:0] r_ext;
		v_ext = {1'b0, v};
		r_ext = {1'b0, ref_angle};
		return (v_ext < r_ext + WINDOW) && (v_ext + WINDOW > r_ext);
	endfunction

	assign open_hit = in_window(avg, open_angle);
	assign snap_hit = in_window(avg, snap_angle);

	// arm first, then the snap window may fire in the same beat
	assign arm_set   = open_hit && !armed_q;
	assign armed_mid = armed_q || arm_set;
	assign armed_nxt = armed_mid && !snap_hit;

	always_comb begin
		res.open_event = arm_set;
		res.snap_event = snap_hit && armed_mid;
		priority if (arm_set) begin
			res.failure_code = FAIL_OPEN_NOT_CLOSED;
		end else if (snap_hit && !armed_mid) begin
			res.failure_code = FAIL_CLOSED_NO_OPEN;
		end else begin
			res.failure_code = FAIL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else if (advance) begin
			armed_q <= armed_nxt;
		end
	end

	// a snap always leaves the detector disarmed
	a_snap_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.snap_event) |=> !armed_q)
		else $error("detector still armed after snap");

	// an open without snap leaves the detector armed
	a_open_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.open_event && !res.snap_event) |=> armed_q)
		else $error("detector not armed after open");

endmodule

[hw/rtl/door_angle_open_snap_detector_top.sv]
// channel  | dir  | payload                                              | beat
// sample   | in   | heading_angle[14:0], tilt_negative                   | valid & ready
// result   | out  | avg_angle[14:0], open_event, snap_event, failure_code | valid & ready
// cfg      | in   | cfg_index selects open/snap angle, cfg_data[14:0]    | cfg_we
//
// one beat per cycle while sample.ready is high; results come from the output register
// the ring of recent headings is a row of cells that shift once per sample
// arst_n resets flags, running average, output valids and cfg; ring cells are not reset
// a two-entry output stage (register plus skid) keeps sample.ready registered;
// a stalled result holds, and sample.ready drops only when both entries are full
module door_angle_open_snap_detector_top (
	input  logic                           clk,
	input  logic                           arst_n,
	dasd_in_if.sink                        sample,
	dasd_out_if.source                     result,
	input  logic                           cfg_we,
	input  logic [dasd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dasd_pkg::ANGLE_W-1:0]   cfg_data
);
	import dasd_pkg::*;

	angle_t      open_angle_q;
	angle_t      snap_angle_q;
	angle_t      running_avg_q;
	logic        primed_q;
	logic        push;
	logic        pop;
	logic [ANGLE_W:0] tilt_sum;
	angle_t      angle;
	angle_t      diff;
	logic        jump;
	angle_t      new_avg;
	angle_t      ring_val [AVG_DEPTH];
	sum_t        sum_chain [AVG_DEPTH+1];
	detect_res_t det;
	out_beat_t   new_beat;
	out_beat_t   out_q;
	logic        out_valid_q;
	out_beat_t   skid_q;
	logic        skid_valid_q;

	// handshake
	assign sample.ready = !skid_valid_q;
	assign push         = sample.valid && sample.ready;
	assign pop          = out_valid_q && result.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_angle_q <= OPEN_ANGLE_RST;
			snap_angle_q <= SNAP_ANGLE_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_OPEN_ANGLE: open_angle_q <= cfg_data;
				REG_SNAP_ANGLE: snap_angle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// tilt correction for a negative tilt: turn by 180 deg, fold back past 360 deg
	always_comb begin
		tilt_sum = {1'b0, sample.data.heading_angle} + DEG180;
		if (!sample.data.tilt_negative) begin
			angle = sample.data.heading_angle;
		end else if (tilt_sum > DEG360) begin
			angle = ANGLE_W'(tilt_sum - DEG360);
		end else begin
			angle = tilt_sum[ANGLE_W-1:0];
		end
	end

	// jump check against the running average; the first sample reloads too
	assign diff = (running_avg_q >= angle) ? (running_avg_q - angle) : (angle - running_avg_q);
	assign jump = !primed_q || (diff > JUMP_LIMIT);

	// ring cells: the newest sample enters cell 0, the oldest falls out the end
	assign sum_chain[0] = '0;

	for (genvar i = 0; i < AVG_DEPTH; i++) begin : g_cell
		angle_t prev;
		if (i == 0) begin : g_head
			assign prev = angle;
		end else begin : g_body
			assign prev = ring_val[i-1];
		end
		dasd_cell u_cell (
			.clk      (clk),
			.shift    (push),
			.load     (jump),
			.fill_val (angle),
			.prev_val (prev),
			.sum_in   (sum_chain[i]),
			.sum_out  (sum_chain[i+1]),
			.val_q    (ring_val[i])
		);
	end

	// floor mean of the ring after this sample
	assign new_avg = jump ? angle : sum_chain[AVG_DEPTH][SUM_W-1:AVG_LOG2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q      <= 1'b0;
			running_avg_q <= '0;
		end else if (push) begin
			primed_q      <= 1'b1;
			running_avg_q <= new_avg;
		end
	end

	// open and snap windows
	dasd_detect u_detect (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (push),
		.avg        (new_avg),
		.open_angle (open_angle_q),
		.snap_angle (snap_angle_q),
		.res        (det)
	);

	always_comb begin
		new_beat.avg_angle    = new_avg;
		new_beat.open_event   = det.open_event;
		new_beat.snap_event   = det.snap_event;
		new_beat.failure_code = det.failure_code;
	end

	// output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= new_beat;
			end
		end else if (push) begin
			skid_q <= new_beat;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// skid entry is only ever used behind a full output register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// a sample taken while the output stalls lands in the skid entry
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && !result.ready) |=> skid_valid_q)
		else $error("stalled beat lost");

	// the first sample primes the ring and passes straight through as the mean
	a_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !primed_q) |=> (primed_q && running_avg_q == $past(angle)))
		else $error("ring not primed by first sample");

endmodule
